@@ hw/rtl/sepf_pkg.sv @@
// Shared types and codes for the shared edge pair finder.
// No dependencies; imported by the interfaces and the top level.
package sepf_pkg;

    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 6;

    localparam logic [1:0] ST_EDGE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vertex_a;
        logic [FIELD_BITS-1:0] vertex_b;
        logic [FIELD_BITS-1:0] vertex_c;
        logic                  restart;
    } item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] earlier_other;
        logic [FIELD_BITS-1:0] edge_first;
        logic [FIELD_BITS-1:0] edge_second;
        logic [FIELD_BITS-1:0] newer_other;
        logic [SLOT_BITS-1:0]  earlier_slot;
        logic                  last;
    } result_t;

endpackage

@@ hw/rtl/sepf_if.sv @@
// Valid/ready channels for triangle input beats and result beats.
// Depends on sepf_pkg.
interface sepf_item_if
    import sepf_pkg::*;
;
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sepf_result_if
    import sepf_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/shared_edge_pair_finder.sv @@
// Shared edge pair finder, top level: scan sequencer, output register.
// Depends on sepf_pkg, sepf_if, sepf_store, sepf_match.
//
// Usage: item_in takes one triangle beat (three vertex indices, restart).
// restart empties the store before the triangle is handled. For each stored
// earlier triangle sharing exactly one edge with it, result_out gives one
// record beat (status edge), in slot order; then one closing beat with last
// set: status done (triangle stored) or full (store held MAX_TRIANGLES
// entries, triangle dropped, no records).
// Timing: item_in is ready only between items. The store RAM is read one slot
// per cycle while result_out does not stall on a record, with a registered
// read, then come the write-back (not when full) and the closing beat. Each
// record passes the RAM read register and then the output register.
// item_in is ready again in the cycle the closing beat is valid.
// When result_out stalls on a record, the scan holds on the pending slot;
// nothing is lost.
// Reset empties the store (count to zero) and drops any pending beat; RAM
// contents are not cleared and need no clearing pass.
module shared_edge_pair_finder
    import sepf_pkg::*;
#(
    parameter int MAX_TRIANGLES = 64,
    parameter int VERTEX_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sepf_item_if.sink            item_in,
    sepf_result_if.source        result_out
);

    localparam int VB = (VERTEX_BITS < FIELD_BITS) ? VERTEX_BITS : FIELD_BITS;
    localparam int AW = $clog2(MAX_TRIANGLES);
    localparam int CW = $clog2(MAX_TRIANGLES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CLOSE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_slot_reg, pend_slot_next;
    logic          close_full_reg, close_full_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_data_reg, out_data_next;
    logic [3*VB-1:0] nt_reg, nt_next;

    logic [CW-1:0] eff_count;
    logic          accept;
    logic          out_busy;
    logic          advance;
    logic          issue;
    logic          wr_en;
    logic [3*VB-1:0] rd_data;

    logic          hit;
    logic [VB-1:0] m_earlier_other;
    logic [VB-1:0] m_edge_first;
    logic [VB-1:0] m_edge_second;
    logic [VB-1:0] m_newer_other;

    sepf_store #(
        .DEPTH (MAX_TRIANGLES),
        .WIDTH (3 * VB),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (nt_reg),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    sepf_match #(
        .VB (VB)
    ) u_match (
        .stored        (rd_data),
        .newer         (nt_reg),
        .hit           (hit),
        .earlier_other (m_earlier_other),
        .edge_first    (m_edge_first),
        .edge_second   (m_edge_second),
        .newer_other   (m_newer_other)
    );

    assign item_in.ready    = (state_reg == S_IDLE);
    assign accept           = item_in.valid && (state_reg == S_IDLE);
    assign out_busy         = out_valid_reg && !result_out.ready;
    assign advance          = !(pend_valid_reg && hit && out_busy);
    assign issue            = (state_reg == S_SCAN) && advance && (rd_idx_reg < count_reg);
    assign wr_en            = (state_reg == S_SCAN) && advance && !issue;
    assign eff_count        = item_in.data.restart ? '0 : count_reg;
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        close_full_next = close_full_reg;
        nt_next         = nt_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    nt_next = {item_in.data.vertex_c[VB-1:0],
                               item_in.data.vertex_b[VB-1:0],
                               item_in.data.vertex_a[VB-1:0]};
                    count_next      = eff_count;
                    rd_idx_next     = '0;
                    pend_valid_next = 1'b0;
                    if (eff_count == CW'(MAX_TRIANGLES))
                    begin
                        close_full_next = 1'b1;
                        state_next      = S_CLOSE;
                    end
                    else
                    begin
                        close_full_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    if (pend_valid_reg && hit)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next.status        = ST_EDGE;
                        out_data_next.earlier_other = FIELD_BITS'(m_earlier_other);
                        out_data_next.edge_first    = FIELD_BITS'(m_edge_first);
                        out_data_next.edge_second   = FIELD_BITS'(m_edge_second);
                        out_data_next.newer_other   = FIELD_BITS'(m_newer_other);
                        out_data_next.earlier_slot  = SLOT_BITS'(pend_slot_reg);
                        out_data_next.last          = 1'b0;
                    end
                    pend_valid_next = issue;
                    pend_slot_next  = rd_idx_reg[AW-1:0];
                    if (issue)
                    begin
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.status = close_full_reg ? ST_FULL : ST_DONE;
                    out_data_next.last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            close_full_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            close_full_reg <= close_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        nt_reg        <= nt_next;
        out_data_reg  <= out_data_next;
    end

endmodule

@@ hw/rtl/sepf_store.sv @@
// Triangle store: single-port-write, single-read synchronous RAM, registered read.
// Read data register holds while no read is issued. No dependencies.
module sepf_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/sepf_match.sv @@
// Nine-way vertex equality compare of one stored triangle against the new one.
// Gives the hit flag and the record vertices. No dependencies.
module sepf_match #(
    parameter int VB = 16
) (
    input  logic [3*VB-1:0] stored,
    input  logic [3*VB-1:0] newer,
    output logic            hit,
    output logic [VB-1:0]   earlier_other,
    output logic [VB-1:0]   edge_first,
    output logic [VB-1:0]   edge_second,
    output logic [VB-1:0]   newer_other
);

    logic [VB-1:0] et [3];
    logic [VB-1:0] nt [3];
    logic [3:0]    hits;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            et[n] = stored[n*VB +: VB];
            nt[n] = newer[n*VB +: VB];
        end
    end

    always_comb
    begin
        hits        = 4'd0;
        edge_first  = '0;
        edge_second = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (et[a] == nt[b])
                begin
                    if (hits == 4'd0)
                    begin
                        edge_first = et[a];
                    end
                    else if (hits == 4'd1)
                    begin
                        edge_second = et[a];
                    end
                    hits = hits + 4'd1;
                end
            end
        end
        hit = (hits == 4'd2);
    end

    // first vertex in own order that is on neither shared vertex
    always_comb
    begin
        earlier_other = '0;
        newer_other   = '0;
        for (int n = 2; n >= 0; n--)
        begin
            if (et[n] != edge_first && et[n] != edge_second)
            begin
                earlier_other = et[n];
            end
            if (nt[n] != edge_first && nt[n] != edge_second)
            begin
                newer_other = nt[n];
            end
        end
    end

endmodule
